FILE: hw/rtl/wss_pkg.sv
package wss_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65535;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PLEN_W      = 5;
  localparam int INDEX_W     = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_START   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_END     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_END_IS_LENGTH  = 3'd5;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } result_t;

endpackage

FILE: hw/rtl/windowed_substring_search.sv
// Accepts one text byte per cycle with no gaps between texts.
// The result for a text is pushed into the result queue when its last byte is
// accepted and is offered on the master side from there; a two-entry result queue
// lets the input keep running while a result waits. Bytes stall only when both
// queue entries are held. Synchronous reset clears the configuration to its
// defaults, the stream state and the result queue.
module windowed_substring_search #(
  parameter int PATTERN_MAX = wss_pkg::PATTERN_MAX_DEF,
  parameter int MAX_TEXT    = wss_pkg::MAX_TEXT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] text_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [15:0] match_index
  output logic                            m_axis_tuser   // [0] found
);
  import wss_pkg::*;

  logic    queue_full;
  logic    res_push;
  result_t res;
  result_t head;

  wss_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .MAX_TEXT    (MAX_TEXT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (s_axis_tvalid),
    .byte_ready (s_axis_tready),
    .text_byte  (s_axis_tdata),
    .is_last    (s_axis_tlast),
    .queue_full (queue_full),
    .res_push   (res_push),
    .res        (res)
  );

  wss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (queue_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  assign m_axis_tdata = head.match_index;
  assign m_axis_tuser = head.found;

endmodule

FILE: hw/rtl/wss_front.sv
module wss_front #(
  parameter int PATTERN_MAX = 16,
  parameter int MAX_TEXT    = 65535
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                byte_valid,
  output logic                                byte_ready,
  input  logic [7:0]                          text_byte,
  input  logic                                is_last,
  input  logic                                queue_full,
  output logic                                res_push,
  output wss_pkg::result_t                    res
);
  import wss_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT + 1);
  localparam int CMP_W = (POS_W > INDEX_W + 1) ? POS_W : INDEX_W + 1;

  function automatic logic [7:0] pattern_byte(input logic [127:0] pat, input int k);
    if (k >= 0 && k < 16) begin
      return pat[8*k +: 8];
    end
    return 8'h00;
  endfunction

  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [PLEN_W-1:0]    pattern_length;
  logic [INDEX_W-1:0]   search_start;
  logic [INDEX_W-1:0]   search_end;
  logic                 end_is_length;

  logic [7:0]           window [PATTERN_MAX];
  logic [7:0]           window_next [PATTERN_MAX];
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_next;
  logic                 overflow;
  logic                 overflow_next;
  logic                 seen;
  logic                 seen_next;
  logic [INDEX_W-1:0]   first;
  logic [INDEX_W-1:0]   first_next;

  logic [PATTERN_MAX-1:0] byte_eq;
  logic                 at_max;
  logic                 plen_ok;
  logic                 long_enough;
  logic                 win_match;
  logic                 take;
  logic                 ok;
  logic [CMP_W-1:0]     len_ext;
  logic [CMP_W-1:0]     plen_ext;
  logic [CMP_W-1:0]     start_ext;
  logic [CMP_W-1:0]     sstart_ext;
  logic [CMP_W-1:0]     end_ext;
  logic                 accept;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      search_start   <= '0;
      search_end     <= '0;
      end_is_length  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        REG_SEARCH_START:   search_start   <= cfg_data[INDEX_W-1:0];
        REG_SEARCH_END:     search_end     <= cfg_data[INDEX_W-1:0];
        REG_END_IS_LENGTH:  end_is_length  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    window_next[0] = text_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      window_next[i] = window[i-1];
    end
  end

  always_comb begin
    at_max        = pos >= POS_W'(MAX_TEXT);
    overflow_next = overflow || at_max;
    pos_next      = at_max ? pos : pos + POS_W'(1);

    len_ext     = CMP_W'(pos_next);
    plen_ext    = CMP_W'(pattern_length);
    sstart_ext  = CMP_W'(search_start);
    start_ext   = len_ext - plen_ext;
    plen_ok     = (pattern_length != '0) && (int'(pattern_length) <= PATTERN_MAX);
    long_enough = len_ext >= plen_ext;

    for (int j = 0; j < PATTERN_MAX; j++) begin
      byte_eq[j] = (j >= int'(pattern_length)) ||
                   (window_next[j] == pattern_byte({pattern_high, pattern_low},
                                                   int'(pattern_length) - 1 - j));
    end
    win_match = plen_ok && long_enough && (&byte_eq);

    take = !overflow_next && !seen && win_match && (start_ext >= sstart_ext) &&
           (start_ext <= CMP_W'({INDEX_W{1'b1}}));
    seen_next  = seen || take;
    first_next = take ? start_ext[INDEX_W-1:0] : first;

    end_ext = end_is_length ? len_ext : CMP_W'(search_end);
    ok = !overflow_next && plen_ok && long_enough && (sstart_ext <= start_ext) &&
         (end_ext <= len_ext) && seen_next && (CMP_W'(first_next) <= end_ext);

    res.found       = ok;
    res.match_index = ok ? first_next : '0;
    res_push        = accept && is_last;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      overflow <= 1'b0;
      seen     <= 1'b0;
      first    <= '0;
    end else if (accept) begin
      if (is_last) begin
        pos      <= '0;
        overflow <= 1'b0;
        seen     <= 1'b0;
        first    <= '0;
      end else begin
        pos      <= pos_next;
        overflow <= overflow_next;
        seen     <= seen_next;
        first    <= first_next;
      end
    end
  end

endmodule

FILE: hw/rtl/wss_queue.sv
module wss_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wss_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output wss_pkg::result_t out_data
);
  import wss_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  logic               do_push;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
